/* hdl/iftsu_pkg.sv */
`default_nettype none
package iftsu_pkg;

	localparam int CHANNELS = 4;
	localparam int DRIVE_W  = 4;
	localparam int PACKED_CH = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ON_PERIODS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_PERIODS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_CYCLES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INJ_ENABLED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BETWEEN_DELAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 3'd7;

	// action codes
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_ARM     = 2'd1;
	localparam logic [1:0] ACT_START   = 2'd2;
	localparam logic [1:0] ACT_DISABLE = 2'd3;

	typedef struct packed {
		logic advance;
		logic arm;
	} chan_ctl_t;

	typedef struct packed {
		logic tick;
		logic start;
		logic disable_seq;
	} filt_ctl_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] injector_drive;
		logic [2:0]         filter_valves;
		logic [3:0]         filter_stage;
	} result_t;

	// channels past the packed word read as zero
	function automatic logic [7:0] packed_byte(input logic [31:0] word, input int ch);
		logic [7:0] b;
		b = 8'd0;
		if (ch < PACKED_CH) begin
			b = word[8*ch +: 8];
		end
		return b;
	endfunction

endpackage
`default_nettype wire

/* hdl/iftsu_channel.sv */
`default_nettype none
module iftsu_channel (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire iftsu_pkg::chan_ctl_t ctl,
	input  wire logic [7:0]          on_period,
	input  wire logic [7:0]          off_period,
	input  wire logic [7:0]          burst,
	output logic                     on_next
);

	logic       on_q;
	logic [7:0] on_cnt_q;
	logic [8:0] off_cnt_q;
	logic [7:0] cyc_cnt_q;

	logic       on_d;
	logic [7:0] on_cnt_d;
	logic [8:0] off_cnt_d;
	logic [7:0] cyc_cnt_d;

	always_comb begin
		on_d      = on_q;
		on_cnt_d  = on_cnt_q;
		off_cnt_d = off_cnt_q;
		cyc_cnt_d = cyc_cnt_q;
		if (ctl.arm) begin
			on_d      = 1'b1;
			on_cnt_d  = 8'd0;
			off_cnt_d = 9'd0;
			cyc_cnt_d = 8'd0;
		end else if (ctl.advance) begin
			if (on_q) begin
				if (on_cnt_q >= on_period) begin
					on_d      = 1'b0;
					on_cnt_d  = 8'd0;
					off_cnt_d = off_cnt_q + 9'd1;
					if (cyc_cnt_q != 8'hFF) begin
						cyc_cnt_d = cyc_cnt_q + 8'd1;
					end
				end else begin
					on_cnt_d = on_cnt_q + 8'd1;
				end
			end else if (off_cnt_q >= {1'b0, off_period}) begin
				if (cyc_cnt_q < burst) begin
					on_d      = 1'b1;
					on_cnt_d  = on_cnt_q + 8'd1;
					off_cnt_d = 9'd0;
				end else begin
					// burst done: hold the off count just past the period
					off_cnt_d = {1'b0, off_period} + 9'd1;
				end
			end else begin
				off_cnt_d = off_cnt_q + 9'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q      <= 1'b0;
			on_cnt_q  <= 8'd0;
			off_cnt_q <= 9'd0;
			cyc_cnt_q <= 8'd0;
		end else begin
			on_q      <= on_d;
			on_cnt_q  <= on_cnt_d;
			off_cnt_q <= off_cnt_d;
			cyc_cnt_q <= cyc_cnt_d;
		end
	end

	assign on_next = on_d;

endmodule
`default_nettype wire

/* hdl/iftsu_filter.sv */
`default_nettype none
module iftsu_filter (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire iftsu_pkg::filt_ctl_t ctl,
	input  wire logic [15:0]          first_delay,
	input  wire logic [15:0]          open_time,
	input  wire logic [15:0]          between_delay,
	input  wire logic [15:0]          repeat_delay,
	output logic [2:0]                valves_next,
	output logic [3:0]                stage_next
);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_START    = 4'd1,
		ST_OPEN1    = 4'd2,
		ST_GAP1     = 4'd3,
		ST_OPEN2    = 4'd4,
		ST_GAP2     = 4'd5,
		ST_OPEN3    = 4'd6,
		ST_REPEAT   = 4'd7,
		ST_DISABLED = 4'd8
	} stage_t;

	stage_t      stage_q, stage_d;
	logic [15:0] tick_q, tick_d, tick_inc, limit;
	logic [2:0]  valve_q, valve_d;
	logic        timed;

	always_comb begin
		tick_inc = tick_q + 16'd1;
		timed    = 1'b1;
		case (stage_q)
			ST_START:  limit = first_delay;
			ST_OPEN1:  limit = open_time;
			ST_GAP1:   limit = between_delay;
			ST_OPEN2:  limit = open_time;
			ST_GAP2:   limit = between_delay;
			ST_OPEN3:  limit = open_time;
			ST_REPEAT: limit = repeat_delay;
			default: begin
				limit = 16'd0;
				timed = 1'b0;
			end
		endcase
	end

	always_comb begin
		stage_d = stage_q;
		tick_d  = tick_q;
		valve_d = valve_q;
		if (ctl.start || ctl.disable_seq) begin
			stage_d = ctl.start ? ST_START : ST_DISABLED;
			tick_d  = 16'd0;
			valve_d = 3'd0;
		end else if (ctl.tick) begin
			tick_d = tick_inc;
			if (stage_q == ST_DISABLED) begin
				tick_d = 16'd0;
			end else if (timed && tick_inc == limit) begin
				tick_d = 16'd0;
				case (stage_q)
					ST_START: begin
						valve_d[0] = 1'b1;
						stage_d    = ST_OPEN1;
					end
					ST_OPEN1: begin
						valve_d[0] = 1'b0;
						stage_d    = ST_GAP1;
					end
					ST_GAP1: begin
						valve_d[1] = 1'b1;
						stage_d    = ST_OPEN2;
					end
					ST_OPEN2: begin
						valve_d[1] = 1'b0;
						stage_d    = ST_GAP2;
					end
					ST_GAP2: begin
						valve_d[2] = 1'b1;
						stage_d    = ST_OPEN3;
					end
					ST_OPEN3: begin
						valve_d[2] = 1'b0;
						stage_d    = ST_REPEAT;
					end
					default: stage_d = ST_START;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			tick_q  <= 16'd0;
			valve_q <= 3'd0;
		end else begin
			stage_q <= stage_d;
			tick_q  <= tick_d;
			valve_q <= valve_d;
		end
	end

	assign valves_next = valve_d;
	assign stage_next  = stage_d;

	// at most one filtration valve open at a time
	a_one_valve: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(valve_q))
		else $error("more than one filtration valve open");
	// no valve open while idle or disabled
	a_closed_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == ST_IDLE || stage_q == ST_DISABLED) |-> valve_q == 3'd0)
		else $error("valve open while filtration idle or disabled");

endmodule
`default_nettype wire

/* hdl/injector_and_filter_tick_sequencer_unit.sv */
`default_nettype none
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     action, fertigation_on
// result    out        result_valid / result_stall injector_drive, filter_valves, filter_stage
// config    in         cfg_we                      cfg_index, cfg_data
//
// One result per item; an item can be taken every cycle while item_stall is low.
// The state update for an item happens in the cycle it transfers; its result lands in the
// output register, or in the skid register when the output register is still held.
// item_stall rises only while the skid register is full.
// Reset clears all sequencer state, configuration and both result valid flags; result data is not reset.
module injector_and_filter_tick_sequencer_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [1:0]                          action,
	input  wire logic                                fertigation_on,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [iftsu_pkg::DRIVE_W-1:0]            injector_drive,
	output logic [2:0]                               filter_valves,
	output logic [3:0]                               filter_stage,
	input  wire logic                                cfg_we,
	input  wire logic [iftsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [iftsu_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration registers
	logic [31:0] on_periods_q;
	logic [31:0] off_periods_q;
	logic [31:0] burst_cycles_q;
	logic        inj_enabled_q;
	logic [15:0] first_delay_q;
	logic [15:0] open_time_q;
	logic [15:0] between_delay_q;
	logic [15:0] repeat_delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_periods_q    <= 32'd0;
			off_periods_q   <= 32'd0;
			burst_cycles_q  <= 32'd0;
			inj_enabled_q   <= 1'b0;
			first_delay_q   <= 16'd0;
			open_time_q     <= 16'd0;
			between_delay_q <= 16'd0;
			repeat_delay_q  <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				iftsu_pkg::CFG_ON_PERIODS:    on_periods_q    <= cfg_data;
				iftsu_pkg::CFG_OFF_PERIODS:   off_periods_q   <= cfg_data;
				iftsu_pkg::CFG_BURST_CYCLES:  burst_cycles_q  <= cfg_data;
				iftsu_pkg::CFG_INJ_ENABLED:   inj_enabled_q   <= cfg_data[0];
				iftsu_pkg::CFG_FIRST_DELAY:   first_delay_q   <= cfg_data[15:0];
				iftsu_pkg::CFG_OPEN_TIME:     open_time_q     <= cfg_data[15:0];
				iftsu_pkg::CFG_BETWEEN_DELAY: between_delay_q <= cfg_data[15:0];
				iftsu_pkg::CFG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// item transfer and decode
	logic                 push;
	logic                 pop;
	logic                 is_tick;
	iftsu_pkg::chan_ctl_t chan_ctl;
	iftsu_pkg::filt_ctl_t filt_ctl;

	assign push    = item_valid && !item_stall;
	assign is_tick = push && action == iftsu_pkg::ACT_TICK;

	assign chan_ctl.advance = is_tick && inj_enabled_q && fertigation_on;
	assign chan_ctl.arm     = push && action == iftsu_pkg::ACT_ARM;

	assign filt_ctl.tick        = is_tick;
	assign filt_ctl.start       = push && action == iftsu_pkg::ACT_START;
	assign filt_ctl.disable_seq = push && action == iftsu_pkg::ACT_DISABLE;

	// injector channels: each holds its own counters and reports its next on bit
	logic [iftsu_pkg::CHANNELS-1:0] on_next;

	for (genvar c = 0; c < iftsu_pkg::CHANNELS; c++) begin : g_chan
		iftsu_channel u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (chan_ctl),
			.on_period  (iftsu_pkg::packed_byte(on_periods_q, c)),
			.off_period (iftsu_pkg::packed_byte(off_periods_q, c)),
			.burst      (iftsu_pkg::packed_byte(burst_cycles_q, c)),
			.on_next    (on_next[c])
		);
	end

	// filtration sequencer
	logic [2:0] valves_next;
	logic [3:0] stage_next;

	iftsu_filter u_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (filt_ctl),
		.first_delay   (first_delay_q),
		.open_time     (open_time_q),
		.between_delay (between_delay_q),
		.repeat_delay  (repeat_delay_q),
		.valves_next   (valves_next),
		.stage_next    (stage_next)
	);

	// assemble the result from the post-item state; only the low channels reach the port
	iftsu_pkg::result_t res_d;

	always_comb begin
		res_d = '0;
		for (int c = 0; c < iftsu_pkg::CHANNELS; c++) begin
			if (c < iftsu_pkg::DRIVE_W) begin
				res_d.injector_drive[c] = on_next[c];
			end
		end
		res_d.filter_valves = valves_next;
		res_d.filter_stage  = stage_next;
	end

	// output register plus skid register
	iftsu_pkg::result_t out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	assign pop        = out_valid_q && !result_stall;
	assign item_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				// drain the skid entry; no transfer can arrive this cycle
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_q <= res_d;
		end
		if (push && out_valid_q && !pop) begin
			skid_q <= res_d;
		end
	end

	assign result_valid   = out_valid_q;
	assign injector_drive = out_q.injector_drive;
	assign filter_valves  = out_q.filter_valves;
	assign filter_stage   = out_q.filter_stage;

	// skid entry only exists behind a held output entry
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");
	// every transfer leaves a result pending
	a_push_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("transfer produced no result");
	// a held skid entry is not lost while the output stays stalled
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && result_stall) |=> skid_valid_q)
		else $error("skid entry dropped while output stalled");

endmodule
`default_nettype wire
